FILE: hdl/utf8_text_field_checker_top_defines.svh
// Assertion macros for the text field checker.
`ifndef UTF8_TEXT_FIELD_CHECKER_TOP_DEFINES_SVH
`define UTF8_TEXT_FIELD_CHECKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define UTF8TFC_ASSERT_SAME(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("utf8tfc same-cycle check failed");
`define UTF8TFC_ASSERT_NEXT(lbl, clk, rstn, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("utf8tfc next-cycle check failed");
`else
`define UTF8TFC_ASSERT_SAME(lbl, clk, rstn, a, c)
`define UTF8TFC_ASSERT_NEXT(lbl, clk, rstn, a, c)
`endif

`endif

FILE: hdl/utf8tfc_pkg.sv
`timescale 1ns / 1ps

package utf8tfc_pkg;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_EMPTY     = 3'd1,
        VERDICT_TOO_LONG  = 3'd2,
        VERDICT_BAD_UTF8  = 3'd3,
        VERDICT_CONTROL   = 3'd4,
        VERDICT_BLANK     = 3'd5
    } verdict_t;

    localparam logic       CFG_MAX_LENGTH  = 1'b0;
    localparam logic       CFG_ALLOW_EMPTY = 1'b1;

    localparam logic [15:0] MAX_LENGTH_RESET  = 16'd16384;
    localparam logic        ALLOW_EMPTY_RESET = 1'b0;

    localparam int          CFG_DATA_W = 16;
    localparam int          CP_W       = 21;
    localparam int          COUNT_W    = 17;

    localparam logic [7:0]  LEAD2_LO   = 8'hc2;
    localparam logic [7:0]  LEAD2_HI   = 8'hdf;
    localparam logic [7:0]  LEAD3_LO   = 8'he0;
    localparam logic [7:0]  LEAD3_HI   = 8'hef;
    localparam logic [7:0]  LEAD4_LO   = 8'hf0;
    localparam logic [7:0]  LEAD4_HI   = 8'hf4;
    localparam logic [7:0]  SPACE_CHAR = 8'h20;
    localparam logic [7:0]  DEL_CHAR   = 8'h7f;

    localparam logic [CP_W-1:0] CP_MAX       = 21'h10ffff;
    localparam logic [CP_W-1:0] SURROGATE_LO = 21'h00d800;
    localparam logic [CP_W-1:0] SURROGATE_HI = 21'h00dfff;

    function automatic logic [CP_W-1:0] min_point(input logic [1:0] cls);
        logic [CP_W-1:0] v;
        case (cls)
            2'd1:    v = 21'h000080;
            2'd2:    v = 21'h000800;
            2'd3:    v = 21'h010000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/utf8_text_field_checker_top.sv
`timescale 1ns / 1ps
`include "utf8_text_field_checker_top_defines.svh"

// Strict UTF-8 text field checker. Each input word carries one byte of a text
// field (s_tuser high) or none (s_tuser low), and s_tlast marks the field's
// final word; one verdict word comes out for every field, in the cycle after
// its last word is taken. The block takes one word per clock: the decoder state
// is updated from the incoming byte into registers, and the verdict sits in
// an output register. While a verdict waits with m_tready low, s_tready is low
// and no input word is taken. Verdicts:
// 0 ok, 1 empty, 2 too long, 3 bad UTF-8, 4 control byte, 5 blank. The
// configuration port must be written only while no field is in progress.
module utf8_text_field_checker_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] text_byte
    input  logic                              s_tuser,   // [0] has_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [2:0] verdict, [7:3] zero
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [utf8tfc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CP_W    = utf8tfc_pkg::CP_W;
    localparam int COUNT_W = utf8tfc_pkg::COUNT_W;

    logic [15:0]          max_length_reg;
    logic                 allow_empty_reg;

    logic [1:0]           pend_reg,    pend_next,    pend_upd;
    logic [CP_W-1:0]      acc_reg,     acc_next,     acc_upd;
    logic [1:0]           cls_reg,     cls_next,     cls_upd;
    logic [COUNT_W-1:0]   count_reg,   count_next,   count_upd;
    logic                 bad_reg,     bad_next,     bad_upd;
    logic                 ctrl_reg,    ctrl_next,    ctrl_upd;
    logic                 nonsp_reg,   nonsp_next,   nonsp_upd;

    logic                 m_valid_reg, m_valid_next;
    utf8tfc_pkg::verdict_t verdict_reg, verdict_next, verdict_calc;

    logic                 accept;
    logic                 close_field;
    logic [CP_W-1:0]      acc_shift;

    assign s_tready    = !m_valid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign close_field = accept && s_tlast;
    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = {5'b0, verdict_reg};
    assign acc_shift   = {acc_reg[CP_W-7:0], s_tdata[5:0]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_length_reg  <= utf8tfc_pkg::MAX_LENGTH_RESET;
            allow_empty_reg <= utf8tfc_pkg::ALLOW_EMPTY_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                utf8tfc_pkg::CFG_MAX_LENGTH:  max_length_reg  <= cfg_wdata[15:0];
                utf8tfc_pkg::CFG_ALLOW_EMPTY: allow_empty_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pend_upd  = pend_reg;
        acc_upd   = acc_reg;
        cls_upd   = cls_reg;
        count_upd = count_reg;
        bad_upd   = bad_reg;
        ctrl_upd  = ctrl_reg;
        nonsp_upd = nonsp_reg;
        if (accept && s_tuser) begin
            if (count_reg != {COUNT_W{1'b1}}) begin
                count_upd = count_reg + 1'b1;
            end
            if (s_tdata < utf8tfc_pkg::SPACE_CHAR || s_tdata == utf8tfc_pkg::DEL_CHAR) begin
                ctrl_upd = 1'b1;
            end
            if (s_tdata != utf8tfc_pkg::SPACE_CHAR) begin
                nonsp_upd = 1'b1;
            end
            if (!bad_reg) begin
                if (pend_reg != 2'd0) begin
                    if (s_tdata[7:6] != 2'b10) begin
                        bad_upd = 1'b1;
                    end else begin
                        acc_upd  = acc_shift;
                        pend_upd = pend_reg - 2'd1;
                        if (pend_reg == 2'd1) begin
                            if (acc_shift < utf8tfc_pkg::min_point(cls_reg) ||
                                acc_shift > utf8tfc_pkg::CP_MAX ||
                                (acc_shift >= utf8tfc_pkg::SURROGATE_LO &&
                                 acc_shift <= utf8tfc_pkg::SURROGATE_HI)) begin
                                bad_upd = 1'b1;
                            end
                        end
                    end
                end else if (s_tdata[7]) begin
                    if (s_tdata >= utf8tfc_pkg::LEAD2_LO && s_tdata <= utf8tfc_pkg::LEAD2_HI) begin
                        pend_upd = 2'd1;
                        acc_upd  = {16'd0, s_tdata[4:0]};
                        cls_upd  = 2'd1;
                    end else if (s_tdata >= utf8tfc_pkg::LEAD3_LO &&
                                 s_tdata <= utf8tfc_pkg::LEAD3_HI) begin
                        pend_upd = 2'd2;
                        acc_upd  = {17'd0, s_tdata[3:0]};
                        cls_upd  = 2'd2;
                    end else if (s_tdata >= utf8tfc_pkg::LEAD4_LO &&
                                 s_tdata <= utf8tfc_pkg::LEAD4_HI) begin
                        pend_upd = 2'd3;
                        acc_upd  = {18'd0, s_tdata[2:0]};
                        cls_upd  = 2'd3;
                    end else begin
                        bad_upd = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        if (!allow_empty_reg && count_upd == '0) begin
            verdict_calc = utf8tfc_pkg::VERDICT_EMPTY;
        end else if (count_upd > {1'b0, max_length_reg}) begin
            verdict_calc = utf8tfc_pkg::VERDICT_TOO_LONG;
        end else if (bad_upd || pend_upd != 2'd0) begin
            verdict_calc = utf8tfc_pkg::VERDICT_BAD_UTF8;
        end else if (ctrl_upd) begin
            verdict_calc = utf8tfc_pkg::VERDICT_CONTROL;
        end else if (!allow_empty_reg && !nonsp_upd) begin
            verdict_calc = utf8tfc_pkg::VERDICT_BLANK;
        end else begin
            verdict_calc = utf8tfc_pkg::VERDICT_OK;
        end
    end

    always_comb begin
        if (close_field) begin
            pend_next  = '0;
            acc_next   = '0;
            cls_next   = '0;
            count_next = '0;
            bad_next   = 1'b0;
            ctrl_next  = 1'b0;
            nonsp_next = 1'b0;
        end else begin
            pend_next  = pend_upd;
            acc_next   = acc_upd;
            cls_next   = cls_upd;
            count_next = count_upd;
            bad_next   = bad_upd;
            ctrl_next  = ctrl_upd;
            nonsp_next = nonsp_upd;
        end
        verdict_next = close_field ? verdict_calc : verdict_reg;
        if (close_field) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            acc_reg     <= '0;
            cls_reg     <= '0;
            count_reg   <= '0;
            bad_reg     <= 1'b0;
            ctrl_reg    <= 1'b0;
            nonsp_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            acc_reg     <= acc_next;
            cls_reg     <= cls_next;
            count_reg   <= count_next;
            bad_reg     <= bad_next;
            ctrl_reg    <= ctrl_next;
            nonsp_reg   <= nonsp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        verdict_reg <= verdict_next;
    end

    `UTF8TFC_ASSERT_NEXT(a_last_gives_word, aclk, aresetn, close_field, m_tvalid)
    `UTF8TFC_ASSERT_NEXT(a_field_cleared, aclk, aresetn, close_field, count_reg == '0 && pend_reg == 2'd0 && !bad_reg)
    `UTF8TFC_ASSERT_SAME(a_open_seq_has_class, aclk, aresetn, pend_reg != 2'd0, cls_reg != 2'd0)
    `UTF8TFC_ASSERT_SAME(a_verdict_range, aclk, aresetn, m_tvalid, m_tdata[2:0] <= 3'd5)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic       has_byte;
    logic [7:0] text_byte;
    logic       last;
} field_word_t;

class field_verdict_board;
    logic [15:0] max_len;
    logic        allow_empty;
    logic [1:0]  pend;
    logic [20:0] acc;
    logic [1:0]  min_cls;
    logic [16:0] count;
    logic        bad;
    logic        ctrl;
    logic        nonspace;
    utf8tfc_pkg::verdict_t verdicts_due[$];
    int          checked;
    int          errors;

    function new();
        max_len = utf8tfc_pkg::MAX_LENGTH_RESET;
        allow_empty = utf8tfc_pkg::ALLOW_EMPTY_RESET;
        checked = 0;
        errors = 0;
        clear();
    endfunction

    function void clear();
        pend = '0;
        acc = '0;
        min_cls = '0;
        count = '0;
        bad = 1'b0;
        ctrl = 1'b0;
        nonspace = 1'b0;
    endfunction

    task report(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        errors++;
    endtask

    function void note_word(input logic has, input logic [7:0] b, input logic lst);
        logic [20:0] lowest;
        logic        strict;
        utf8tfc_pkg::verdict_t v;
        if (has) begin
            if (count != '1) count++;
            if (b < utf8tfc_pkg::SPACE_CHAR || b == utf8tfc_pkg::DEL_CHAR) ctrl = 1'b1;
            if (b != utf8tfc_pkg::SPACE_CHAR) nonspace = 1'b1;
            if (!bad) begin
                if (pend != 0) begin
                    if (b[7:6] != 2'b10) begin
                        bad = 1'b1;
                    end else begin
                        acc = {acc[14:0], b[5:0]};
                        pend--;
                        if (pend == 0) begin
                            case (min_cls)
                                2'd1:    lowest = 21'h000080;
                                2'd2:    lowest = 21'h000800;
                                2'd3:    lowest = 21'h010000;
                                default: lowest = 21'h000000;
                            endcase
                            if (acc < lowest || acc > utf8tfc_pkg::CP_MAX ||
                                (acc >= utf8tfc_pkg::SURROGATE_LO &&
                                 acc <= utf8tfc_pkg::SURROGATE_HI)) bad = 1'b1;
                        end
                    end
                end else if (b >= utf8tfc_pkg::LEAD2_LO && b <= utf8tfc_pkg::LEAD2_HI) begin
                    pend = 2'd1;
                    acc = {16'd0, b[4:0]};
                    min_cls = 2'd1;
                end else if (b >= utf8tfc_pkg::LEAD3_LO && b <= utf8tfc_pkg::LEAD3_HI) begin
                    pend = 2'd2;
                    acc = {17'd0, b[3:0]};
                    min_cls = 2'd2;
                end else if (b >= utf8tfc_pkg::LEAD4_LO && b <= utf8tfc_pkg::LEAD4_HI) begin
                    pend = 2'd3;
                    acc = {18'd0, b[2:0]};
                    min_cls = 2'd3;
                end else if (b[7]) begin
                    bad = 1'b1;
                end
            end
        end
        if (lst) begin
            strict = !allow_empty;
            if (strict && count == 0) v = utf8tfc_pkg::VERDICT_EMPTY;
            else if (count > {1'b0, max_len}) v = utf8tfc_pkg::VERDICT_TOO_LONG;
            else if (bad || pend != 0) v = utf8tfc_pkg::VERDICT_BAD_UTF8;
            else if (ctrl) v = utf8tfc_pkg::VERDICT_CONTROL;
            else if (strict && !nonspace) v = utf8tfc_pkg::VERDICT_BLANK;
            else v = utf8tfc_pkg::VERDICT_OK;
            verdicts_due.insert(verdicts_due.size(), v);
            clear();
        end
    endfunction

    task check_verdict(input logic [7:0] data);
        utf8tfc_pkg::verdict_t want;
        if (verdicts_due.size() == 0) begin
            report($sformatf("verdict word %h with no field pending", data));
        end else begin
            want = verdicts_due.pop_front();
            if (data !== {5'd0, want})
                report($sformatf("field %0d: verdict word %h, expected %s",
                                 checked, data, want.name()));
            checked++;
        end
    endtask
endclass

module testbench;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'd0;
    logic                  s_tuser = 1'b0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = utf8tfc_pkg::CFG_MAX_LENGTH;
    logic [utf8tfc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    int send_idle = 14;
    int recv_idle = 73;

    field_verdict_board board;
    logic [7:0]         text_q[$];
    field_word_t        field_q[$];

    utf8_text_field_checker_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_verdict(m_tdata);
        end
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    task automatic send_word(input logic has, input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= has;
        s_tdata <= b;
        s_tlast <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_word(has, b, lst);
    endtask

    task automatic set_config(input logic [15:0] max_len, input logic allow);
        cfg_we <= 1'b1;
        cfg_index <= utf8tfc_pkg::CFG_MAX_LENGTH;
        cfg_wdata <= max_len;
        @(posedge aclk);
        cfg_index <= utf8tfc_pkg::CFG_ALLOW_EMPTY;
        cfg_wdata <= {15'd0, allow};
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.max_len = max_len;
        board.allow_empty = allow;
    endtask

    task automatic wait_drained();
        int guard;
        s_tvalid <= 1'b0;
        for (guard = 0; board.verdicts_due.size() != 0 && guard < 100000; guard++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic void add_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    function automatic void add_word(input logic has, input logic [7:0] b, input logic lst);
        field_word_t w;
        w.has_byte = has;
        w.text_byte = b;
        w.last = lst;
        field_q.insert(field_q.size(), w);
    endfunction

    function automatic logic [20:0] pick_cp(input logic [20:0] lo, input logic [20:0] hi);
        case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            default: return 21'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic void add_seq(input logic [20:0] cp, input int n);
        case (n)
            2: begin
                add_byte({3'b110, cp[10:6]});
                add_byte({2'b10, cp[5:0]});
            end
            3: begin
                add_byte({4'b1110, cp[15:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
            default: begin
                add_byte({5'b11110, cp[20:18]});
                add_byte({2'b10, cp[17:12]});
                add_byte({2'b10, cp[11:6]});
                add_byte({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic void add_char(input bit defect);
        logic [20:0] cp;
        logic [7:0]  b;
        int          n;
        if (!defect) begin
            case ($urandom_range(9))
                0, 1, 2, 3: add_byte(8'($urandom_range(8'h7e, 8'h21)));
                4:          add_byte(utf8tfc_pkg::SPACE_CHAR);
                5, 6:       add_seq(pick_cp(21'h80, 21'h7ff), 2);
                7: begin
                    if ($urandom_range(3) == 0)
                        cp = $urandom_range(1) ? 21'hd7ff : 21'he000;
                    else
                        cp = pick_cp(21'h800, 21'hffff);
                    if (cp >= utf8tfc_pkg::SURROGATE_LO && cp <= utf8tfc_pkg::SURROGATE_HI)
                        cp = cp ^ 21'h2000;
                    add_seq(cp, 3);
                end
                default:    add_seq(pick_cp(21'h10000, 21'h10ffff), 4);
            endcase
        end else begin
            n = $urandom_range(4, 2);
            case ($urandom_range(8))
                0: add_byte(8'($urandom_range(8'h1f)));
                1: add_byte(utf8tfc_pkg::DEL_CHAR);
                2: add_seq(pick_cp(21'h0, n == 2 ? 21'h7f : n == 3 ? 21'h7ff : 21'hffff), n);
                3: add_seq(pick_cp(utf8tfc_pkg::SURROGATE_LO, utf8tfc_pkg::SURROGATE_HI), 3);
                4: add_seq(pick_cp(21'h110000, 21'h1fffff), 4);
                5, 6: begin
                    if (n == 2) cp = pick_cp(21'h80, 21'h7ff);
                    else if (n == 3) cp = pick_cp(21'h800, 21'hd7ff);
                    else cp = pick_cp(21'h10000, 21'h10ffff);
                    add_seq(cp, n);
                    if ($urandom_range(1)) begin
                        repeat ($urandom_range(n - 1, 1)) void'(text_q.pop_back());
                    end else begin
                        b = 8'($urandom);
                        if (b[7:6] == 2'b10) b[6] = 1'b1;
                        text_q[text_q.size() - 1 - $urandom_range(n - 2)] = b;
                    end
                end
                7: add_byte(8'($urandom_range(8'hbf, 8'h80)));
                default: add_byte($urandom_range(1) ? 8'($urandom_range(8'hff, 8'hf5))
                                                    : 8'($urandom_range(8'hc1, 8'hc0)));
            endcase
        end
    endfunction

    task automatic build_field(input int max_chars);
        int flavor;
        int nchars;
        int spot;
        text_q.delete();
        field_q.delete();
        flavor = $urandom_range(99);
        nchars = $urandom_range(max_chars);
        if (flavor < 60) begin
            repeat (nchars) add_char(1'b0);
        end else if (flavor < 80) begin
            spot = $urandom_range(nchars);
            for (int i = 0; i <= nchars; i++) add_char(i == spot);
        end else if (flavor < 90) begin
            repeat (nchars) add_byte(8'($urandom));
        end else if (flavor >= 95) begin
            repeat (nchars) add_byte(utf8tfc_pkg::SPACE_CHAR);
        end
        foreach (text_q[i]) begin
            if ($urandom_range(11) == 0) add_word(1'b0, 8'($urandom), 1'b0);
            add_word(1'b1, text_q[i], 1'b0);
        end
        if (text_q.size() != 0 && $urandom_range(9) < 7)
            field_q[field_q.size() - 1].last = 1'b1;
        else
            add_word(1'b0, 8'($urandom), 1'b1);
    endtask

    task automatic run_random(input int quota, input int max_chars);
        int done;
        done = 0;
        while (done < quota) begin
            build_field(max_chars);
            foreach (field_q[i]) begin
                send_word(field_q[i].has_byte, field_q[i].text_byte, field_q[i].last);
                if (field_q[i].has_byte || field_q[i].last) done++;
            end
        end
    endtask

    initial begin
        board = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(1'b0, 8'h00, 1'b1);
        send_word(1'b0, 8'hff, 1'b0);
        send_word(1'b1, 8'h41, 1'b1);
        send_word(1'b1, utf8tfc_pkg::SPACE_CHAR, 1'b1);
        send_word(1'b1, 8'h00, 1'b1);
        send_word(1'b1, utf8tfc_pkg::DEL_CHAR, 1'b1);
        send_word(1'b1, 8'hc2, 1'b0);
        send_word(1'b1, 8'h80, 1'b1);
        send_word(1'b1, 8'hc0, 1'b1);
        send_word(1'b1, 8'hed, 1'b0);
        send_word(1'b1, 8'ha0, 1'b0);
        send_word(1'b1, 8'h80, 1'b1);
        send_word(1'b1, 8'hf4, 1'b0);
        send_word(1'b1, 8'h90, 1'b0);
        send_word(1'b1, 8'h80, 1'b0);
        send_word(1'b1, 8'h80, 1'b1);
        send_word(1'b1, 8'he2, 1'b0);
        send_word(1'b1, 8'h82, 1'b1);
        send_word(1'b1, 8'hff, 1'b0);
        send_word(1'b1, 8'h41, 1'b1);
        send_word(1'b1, 8'hf4, 1'b0);
        send_word(1'b1, 8'h8f, 1'b0);
        send_word(1'b1, 8'hbf, 1'b0);
        send_word(1'b1, 8'hbf, 1'b1);
        run_random(200, 6);

        wait_drained();
        set_config(16'd1, 1'b1);
        run_random(200, 6);

        wait_drained();
        send_idle = 73;
        recv_idle = 14;
        set_config(16'd0, 1'b0);
        run_random(150, 4);

        wait_drained();
        set_config(16'($urandom_range(12, 2)), 1'b1);
        run_random(250, 8);

        wait_drained();
        send_idle = 0;
        recv_idle = 0;
        set_config(16'($urandom_range(12, 2)), 1'b0);
        run_random(250, 10);

        wait_drained();
        set_config(16'hffff, 1'b1);
        run_random(200, 14);

        wait_drained();
        if (board.verdicts_due.size() != 0)
            board.report($sformatf("%0d verdicts never arrived", board.verdicts_due.size()));
        if (board.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule
